/* rtl/mcr_pkg.sv */
package mcr_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int IN_WIDTH    = 16;
  localparam int OUT_WIDTH   = COORD_WIDTH + 1;
  localparam int DEC_WIDTH   = COORD_WIDTH + 2;
  localparam int COLOR_WIDTH = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PIX_PER_GROUP = 8;
  localparam int IDX_W         = $clog2(PIX_PER_GROUP);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // one group of pixels for the back end to emit
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] ox;
    logic signed [COORD_WIDTH-1:0] oy;
    logic [COLOR_WIDTH-1:0]        color;
    logic                          fin;
    logic                          single;
  } job_t;

endpackage

/* rtl/mcr_if.sv */
interface mcr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [mcr_pkg::IN_WIDTH-1:0]   center_x;
  logic signed [mcr_pkg::IN_WIDTH-1:0]   center_y;
  logic signed [mcr_pkg::IN_WIDTH-1:0]   radius;
  logic [mcr_pkg::COLOR_WIDTH-1:0]       pixel_color;

  modport source (output valid, kind, center_x, center_y, radius, pixel_color,
                  input ready);
  modport sink (input valid, kind, center_x, center_y, radius, pixel_color,
                output ready);
endinterface

interface mcr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mcr_pkg::OUT_WIDTH-1:0]  pixel_x;
  logic signed [mcr_pkg::OUT_WIDTH-1:0]  pixel_y;
  logic [mcr_pkg::COLOR_WIDTH-1:0]       out_color;
  logic                                  last;

  modport source (output valid, pixel_x, pixel_y, out_color, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, out_color, last, output ready);
endinterface

/* rtl/mcr_front.sv */
module mcr_front (
  input  logic          clk,
  input  logic          rst_n,
  mcr_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output mcr_pkg::job_t job
);

  logic                                     active_r, active_nxt;
  logic signed [mcr_pkg::COORD_WIDTH-1:0]   ctr_x_r, ctr_x_nxt;
  logic signed [mcr_pkg::COORD_WIDTH-1:0]   ctr_y_r, ctr_y_nxt;
  logic signed [mcr_pkg::COORD_WIDTH-1:0]   off_x_r, off_x_nxt;
  logic signed [mcr_pkg::COORD_WIDTH-1:0]   off_y_r, off_y_nxt;
  logic signed [mcr_pkg::DEC_WIDTH-1:0]     dec_r, dec_nxt;
  logic [mcr_pkg::COLOR_WIDTH-1:0]          color_r, color_nxt;

  logic signed [mcr_pkg::OUT_WIDTH-1:0]     x_inc, y_dec;
  logic signed [mcr_pkg::DEC_WIDTH-1:0]     d_lt, d_ge;
  logic                                     accept, rad_pos, fin;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rad_pos     = !in_ch.radius[mcr_pkg::IN_WIDTH-1] && (in_ch.radius != '0);

  // step update with unwrapped x + 1 and y - 1
  assign x_inc = mcr_pkg::OUT_WIDTH'(off_x_r) + mcr_pkg::OUT_WIDTH'(1);
  assign y_dec = mcr_pkg::OUT_WIDTH'(off_y_r) - mcr_pkg::OUT_WIDTH'(1);
  assign d_lt  = dec_r + (mcr_pkg::DEC_WIDTH'(x_inc) <<< 1) + mcr_pkg::DEC_WIDTH'(1);
  assign d_ge  = dec_r + ((mcr_pkg::DEC_WIDTH'(x_inc) - mcr_pkg::DEC_WIDTH'(y_dec)) <<< 1)
                 + mcr_pkg::DEC_WIDTH'(1);

  always_comb begin
    active_nxt = active_r;
    ctr_x_nxt  = ctr_x_r;
    ctr_y_nxt  = ctr_y_r;
    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    dec_nxt    = dec_r;
    color_nxt  = color_r;
    push       = 1'b0;
    if (accept) begin
      if (in_ch.kind == mcr_pkg::KIND_START) begin
        ctr_x_nxt = mcr_pkg::COORD_WIDTH'(in_ch.center_x);
        ctr_y_nxt = mcr_pkg::COORD_WIDTH'(in_ch.center_y);
        color_nxt = in_ch.pixel_color;
        off_x_nxt = '0;
        push      = 1'b1;
        if (rad_pos) begin
          off_y_nxt = mcr_pkg::COORD_WIDTH'(in_ch.radius);
          dec_nxt   = mcr_pkg::DEC_WIDTH'(1) - mcr_pkg::DEC_WIDTH'(in_ch.radius);
        end else begin
          off_y_nxt = '0;
          dec_nxt   = '0;
        end
      end else if (active_r) begin
        push      = 1'b1;
        off_x_nxt = x_inc[mcr_pkg::COORD_WIDTH-1:0];
        if (dec_r[mcr_pkg::DEC_WIDTH-1]) begin
          dec_nxt = d_lt;
        end else begin
          off_y_nxt = y_dec[mcr_pkg::COORD_WIDTH-1:0];
          dec_nxt   = d_ge;
        end
      end
    end
    fin = !(off_x_nxt < off_y_nxt);
    if (accept && in_ch.kind == mcr_pkg::KIND_START && !rad_pos) begin
      active_nxt = 1'b0;
    end else if (push) begin
      active_nxt = !fin;
    end
    job.cx     = ctr_x_nxt;
    job.cy     = ctr_y_nxt;
    job.ox     = off_x_nxt;
    job.oy     = off_y_nxt;
    job.color  = color_nxt;
    job.fin    = fin;
    job.single = (in_ch.kind == mcr_pkg::KIND_START) && !rad_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ctr_x_r  <= '0;
      ctr_y_r  <= '0;
      off_x_r  <= '0;
      off_y_r  <= '0;
      dec_r    <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      ctr_x_r  <= ctr_x_nxt;
      ctr_y_r  <= ctr_y_nxt;
      off_x_r  <= off_x_nxt;
      off_y_r  <= off_y_nxt;
      dec_r    <= dec_nxt;
      color_r  <= color_nxt;
    end
  end

endmodule

/* rtl/mcr_queue.sv */
module mcr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mcr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output mcr_pkg::job_t head
);

  mcr_pkg::job_t                mem_r [mcr_pkg::QDEPTH];
  logic [mcr_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mcr_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == mcr_pkg::QCNT_W'(mcr_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mcr_pkg::QPTR_W'(mcr_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + mcr_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcr_pkg::QPTR_W'(mcr_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + mcr_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + mcr_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - mcr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mcr_pkg::QCNT_W'(mcr_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

/* rtl/mcr_back.sv */
module mcr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  mcr_pkg::job_t q_head,
  output logic          q_pop,
  mcr_out_if.source     out_ch
);

  mcr_pkg::job_t                         cur_r, cur_nxt;
  logic                                  busy_r, busy_nxt;
  logic [mcr_pkg::IDX_W-1:0]             idx_r, idx_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic signed [mcr_pkg::OUT_WIDTH-1:0]  px_r, py_r, px, py;
  logic [mcr_pkg::COLOR_WIDTH-1:0]       color_r;
  logic                                  last_r, last_pix;
  logic signed [mcr_pkg::OUT_WIDTH-1:0]  cx, cy, a, b;
  logic                                  advance, final_pix;

  assign cx = mcr_pkg::OUT_WIDTH'(cur_r.cx);
  assign cy = mcr_pkg::OUT_WIDTH'(cur_r.cy);
  // swap offsets for the second half of the octants
  assign a  = idx_r[2] ? mcr_pkg::OUT_WIDTH'(cur_r.oy) : mcr_pkg::OUT_WIDTH'(cur_r.ox);
  assign b  = idx_r[2] ? mcr_pkg::OUT_WIDTH'(cur_r.ox) : mcr_pkg::OUT_WIDTH'(cur_r.oy);
  assign px = idx_r[0] ? cx - a : cx + a;
  assign py = idx_r[1] ? cy - b : cy + b;

  assign final_pix = cur_r.single || (idx_r == mcr_pkg::IDX_W'(mcr_pkg::PIX_PER_GROUP - 1));
  assign last_pix  = cur_r.single || (final_pix && cur_r.fin);
  assign advance   = busy_r && (!out_valid_r || out_ch.ready);
  assign q_pop     = q_not_empty && (!busy_r || (advance && final_pix));

  always_comb begin
    cur_nxt       = cur_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + mcr_pkg::IDX_W'(1);
      if (final_pix) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end
    end
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (advance) begin
      px_r    <= px;
      py_r    <= py;
      color_r <= cur_r.color;
      last_r  <= last_pix;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_x   = px_r;
  assign out_ch.pixel_y   = py_r;
  assign out_ch.out_color = color_r;
  assign out_ch.last      = last_r;

  a_single_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cur_r.single) |-> idx_r == '0)
    else $error("single-pixel job past its first pixel");
  a_idle_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> idx_r == '0)
    else $error("pixel index not cleared when idle");

endmodule

/* rtl/midpoint_circle_rasterizer_top.sv */
// midpoint circle rasterizer
// in_ch carries items: kind start loads center, radius and color; kind step
// advances the running circle by one octant point. out_ch carries pixels with
// their color and a last flag on the final pixel of each circle.
// a start with radius zero or below gives one pixel, the center, marked last.
// a start with positive radius and every step while a circle runs give eight
// pixels; a step with no circle running is taken and gives nothing.
// the front end updates the circle state in the cycle an item is taken and
// queues one pixel group; the back end emits one pixel per cycle while
// out_ch.ready is high. the first pixel of an item passes the group queue,
// the back end's group register and the output register before it is valid.
// pixels leave through the single pixel output register; the two-entry group
// queue lets the front take the next item while the back end is still emitting.
// when out_ch.ready is low the output register holds, the back end stops and
// in_ch.ready falls once the queue is full. reset clears the circle state,
// the queue and the output valid; no pixel is pending after reset.
module midpoint_circle_rasterizer_top (
  input  logic      clk,
  input  logic      rst_n,
  mcr_in_if.sink    in_ch,
  mcr_out_if.source out_ch
);

  mcr_pkg::job_t push_job, head_job;
  logic          push, full, pop, not_empty;

  mcr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .job    (push_job)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head_job)
  );

  mcr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_head      (head_job),
    .q_pop       (pop),
    .out_ch      (out_ch)
  );

endmodule

/* tb/tb_midpoint_circle_rasterizer_top.sv */
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer_top;
  import mcr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic                         kind;
    logic signed [IN_WIDTH-1:0]   center_x;
    logic signed [IN_WIDTH-1:0]   center_y;
    logic signed [IN_WIDTH-1:0]   radius;
    logic [COLOR_WIDTH-1:0]       pixel_color;
  } circle_cmd_t;

  typedef struct {
    logic signed [OUT_WIDTH-1:0]  px;
    logic signed [OUT_WIDTH-1:0]  py;
    logic [COLOR_WIDTH-1:0]       color;
    logic                         last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  mcr_in_if  in_ch ();
  mcr_out_if out_ch ();

  midpoint_circle_rasterizer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  circle_cmd_t circle_cmds[$];
  pixel_t      expected_pixels[$];
  int          cmds_queued = 0;
  int          cmds_taken  = 0;
  int          fail_count  = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_stamp    = 0;

  // shadow circle state
  logic                          circ_active = 1'b0;
  logic signed [COORD_WIDTH-1:0] circ_cx = '0;
  logic signed [COORD_WIDTH-1:0] circ_cy = '0;
  logic signed [COORD_WIDTH-1:0] circ_ox = '0;
  logic signed [COORD_WIDTH-1:0] circ_oy = '0;
  logic signed [DEC_WIDTH-1:0]   circ_dec = '0;
  logic [COLOR_WIDTH-1:0]        circ_color = '0;

  function automatic void push_pixel(input logic signed [OUT_WIDTH-1:0] px,
                                     input logic signed [OUT_WIDTH-1:0] py,
                                     input logic last);
    pixel_t p;
    p.px = px;
    p.py = py;
    p.color = circ_color;
    p.last = last;
    expected_pixels.push_back(p);
  endfunction

  function automatic void emit_octants();
    logic signed [OUT_WIDTH-1:0] cx, cy, ox, oy;
    logic fin;
    cx = circ_cx;
    cy = circ_cy;
    ox = circ_ox;
    oy = circ_oy;
    fin = !(circ_ox < circ_oy);
    push_pixel(cx + ox, cy + oy, 1'b0);
    push_pixel(cx - ox, cy + oy, 1'b0);
    push_pixel(cx + ox, cy - oy, 1'b0);
    push_pixel(cx - ox, cy - oy, 1'b0);
    push_pixel(cx + oy, cy + ox, 1'b0);
    push_pixel(cx - oy, cy + ox, 1'b0);
    push_pixel(cx + oy, cy - ox, 1'b0);
    push_pixel(cx - oy, cy - ox, fin);
    if (fin) circ_active = 1'b0;
  endfunction

  function automatic void rasterize_item(input circle_cmd_t cmd);
    int x, y, d;
    if (cmd.kind == KIND_START) begin
      circ_cx = cmd.center_x;
      circ_cy = cmd.center_y;
      circ_color = cmd.pixel_color;
      circ_ox = '0;
      if (cmd.radius <= 0) begin
        circ_active = 1'b0;
        circ_oy = '0;
        circ_dec = '0;
        push_pixel(circ_cx, circ_cy, 1'b1);
      end else begin
        circ_active = 1'b1;
        circ_oy = cmd.radius;
        circ_dec = 18'(1 - int'(cmd.radius));
        emit_octants();
      end
    end else if (circ_active) begin
      x = int'(circ_ox) + 1;
      y = circ_oy;
      d = circ_dec;
      if (d < 0) begin
        d += 2 * x + 1;
      end else begin
        y -= 1;
        d += 2 * (x - y) + 1;
      end
      circ_ox = 16'(x);
      circ_oy = 16'(y);
      circ_dec = 18'(d);
      emit_octants();
    end
  endfunction

  function automatic int steps_to_close(input int r);
    int x, y, d, n;
    x = 0;
    y = r;
    d = 1 - r;
    n = 0;
    while (x < y) begin
      x++;
      if (d < 0) begin
        d += 2 * x + 1;
      end else begin
        y--;
        d += 2 * (x - y) + 1;
      end
      n++;
    end
    return n;
  endfunction

  task automatic add_cmd(input logic kind, input logic signed [IN_WIDTH-1:0] cx,
                         input logic signed [IN_WIDTH-1:0] cy,
                         input logic signed [IN_WIDTH-1:0] r,
                         input logic [COLOR_WIDTH-1:0] color);
    circle_cmd_t cmd;
    cmd.kind = kind;
    cmd.center_x = cx;
    cmd.center_y = cy;
    cmd.radius = r;
    cmd.pixel_color = color;
    circle_cmds.push_back(cmd);
    cmds_queued++;
  endtask

  // step fields are ignored, so they carry noise
  task automatic add_step();
    add_cmd(KIND_STEP, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic add_start(input logic signed [IN_WIDTH-1:0] r);
    add_cmd(KIND_START, 16'($urandom), 16'($urandom), r, $urandom);
  endtask

  task automatic add_random_traffic(input int n);
    int target, roll, steps;
    logic signed [IN_WIDTH-1:0] r;
    target = cmds_queued + n;
    while (cmds_queued < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        if ($urandom_range(9) == 0) begin
          r = 16'($urandom_range(32767, 25));
          steps = $urandom_range(6);
        end else begin
          r = 16'($urandom_range(24, 1));
          steps = steps_to_close(r);
          roll = $urandom_range(9);
          if (roll == 0) begin
            steps = steps + 1;
          end else if (roll == 1) begin
            steps = $urandom_range(steps);
          end
        end
        add_start(r);
        repeat (steps) add_step();
      end else if (roll < 80) begin
        r = ($urandom_range(3) == 0) ? 16'sd0 : {1'b1, 15'($urandom)};
        add_start(r);
      end else if (roll < 90) begin
        add_step();
      end else begin
        add_cmd(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    while (cmds_taken != cmds_queued || expected_pixels.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive
    circle_cmd_t cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd.kind = in_ch.kind;
        cmd.center_x = in_ch.center_x;
        cmd.center_y = in_ch.center_y;
        cmd.radius = in_ch.radius;
        cmd.pixel_color = in_ch.pixel_color;
        rasterize_item(cmd);
        cmds_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (circle_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd = circle_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= cmd.kind;
          in_ch.center_x <= cmd.center_x;
          in_ch.center_y <= cmd.center_y;
          in_ch.radius <= cmd.radius;
          in_ch.pixel_color <= cmd.pixel_color;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin : watch
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d", out_ch.pixel_x, out_ch.pixel_y);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.pixel_x !== want.px) begin
            $error("pixel_x expected %0d got %0d", want.px, out_ch.pixel_x);
            fail_count++;
          end
          if (out_ch.pixel_y !== want.py) begin
            $error("pixel_y expected %0d got %0d", want.py, out_ch.pixel_y);
            fail_count++;
          end
          if (out_ch.out_color !== want.color) begin
            $error("out_color expected %h got %h", want.color, out_ch.out_color);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last expected %0b got %0b", want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      if (hold_seen != hold_stamp) begin
        hold_seen = hold_stamp;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_START;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.radius = '0;
    in_ch.pixel_color = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    add_cmd(KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 32'h0);
    add_cmd(KIND_START, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
    add_cmd(KIND_START, -16'sd32768, -16'sd32768, -16'sd32768, 32'hffff_ffff);
    add_cmd(KIND_START, 16'sd32767, 16'sd32767, -16'sd1, 32'h1234_5678);
    add_cmd(KIND_START, 16'sd32767, -16'sd32768, 16'sd1, 32'ha5a5_5a5a);
    add_step();
    add_step();
    add_cmd(KIND_START, 16'sd32767, 16'sd32767, 16'sd32767, 32'hffff_ffff);
    repeat (3) add_step();
    // restart while a circle runs
    add_cmd(KIND_START, -16'sd32768, 16'sd32767, 16'sd5, 32'h5a5a_a5a5);
    repeat (steps_to_close(5)) add_step();
    add_cmd(KIND_START, -16'sd32768, -16'sd32768, 16'sd32767, 32'h0f0f_f0f0);
    repeat (2) add_step();
    add_cmd(KIND_START, 16'sd100, -16'sd100, 16'sd0, 32'hdead_beef);
    add_step();
    wait_drained();

    // long receiver hold-off with the sender still offering
    hold_stamp++;
    add_random_traffic(40);
    wait_drained();

    send_idle_pct = 64;
    add_random_traffic(40);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 64;
    add_random_traffic(40);
    wait_drained();

    send_idle_pct = 36;
    stall_pct = 36;
    add_random_traffic(40);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
